/* hdl/tptq_pkg.sv */
// Package for the timed priority task queue: widths, defaults, operation codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package tptq_pkg;

    // Default sizing of the store
    localparam int DEPTH_DEF     = 16;
    localparam int PRI_W_DEF     = 8;
    localparam int TIME_W_DEF    = 32;

    // Fixed port widths
    localparam int FUNC_W        = 2;
    localparam int ID_W          = 16;
    localparam int PRI_IN_W      = 8;
    localparam int TIME_IN_W     = 32;

    // Most results that one dispatch request may produce
    localparam int RESULT_LIMIT  = 16;

    typedef enum logic [FUNC_W-1:0] {
        F_PUSH       = 2'd0,
        F_CANCEL     = 2'd1,
        F_DISP_READY = 2'd2,
        F_DISP_ALL   = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_CAN_SCAN,
        S_CAN_DRAIN,
        S_CAN_DONE,
        S_DSP_SCAN,
        S_DSP_DRAIN,
        S_DSP_DECIDE,
        S_DSP_FLUSH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;         // latch request fields, clear scan bookkeeping
        logic push_do;      // write lowest free slot, emit push result
        logic scan_issue;   // read slot at scan pointer, advance pointer
        logic cancel_emit;  // emit cancel result
        logic decide;       // act on the best candidate of a finished scan
        logic flush;        // emit the held dispatch as the final result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;    // scan pointer is on the last slot
        logic take;         // candidate gets dispatched
        logic limit_hit;    // this dispatch reaches the result limit
    } t_status;

endpackage

/* hdl/tptq_ctrl.sv */
// Controller state machine for the timed priority task queue.
// Depends on tptq_pkg; drives tptq_dp through t_cmd and reads t_status.
`timescale 1ns / 1ps

module tptq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  tptq_pkg::t_func   i_func,
    input  tptq_pkg::t_status i_status,
    output tptq_pkg::t_cmd    o_cmd,
    output logic              busy
);
    import tptq_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    case (i_func)
                        F_PUSH:   n_state = S_PUSH;
                        F_CANCEL: n_state = S_CAN_SCAN;
                        default:  n_state = S_DSP_SCAN;
                    endcase
                end
            end
            S_PUSH: begin
                o_cmd.push_do = 1'b1;
                n_state       = S_IDLE;
            end
            S_CAN_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_CAN_DRAIN;
                end
            end
            S_CAN_DRAIN: begin
                n_state = S_CAN_DONE;
            end
            S_CAN_DONE: begin
                o_cmd.cancel_emit = 1'b1;
                n_state           = S_IDLE;
            end
            S_DSP_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DSP_DRAIN;
                end
            end
            S_DSP_DRAIN: begin
                n_state = S_DSP_DECIDE;
            end
            S_DSP_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_status.take && i_status.limit_hit) begin
                    n_state = S_DSP_FLUSH;
                end else if (i_status.take) begin
                    n_state = S_DSP_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DSP_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

/* hdl/tptq_dp.sv */
// Datapath for the timed priority task queue: slot store, valid bits, scan
// pipeline, best-candidate tracking and the result register. Depends on tptq_pkg.
`timescale 1ns / 1ps

module tptq_dp #(
    parameter int DEPTH          = tptq_pkg::DEPTH_DEF,
    parameter int PRIORITY_WIDTH = tptq_pkg::PRI_W_DEF,
    parameter int TIME_WIDTH     = tptq_pkg::TIME_W_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tptq_pkg::t_cmd                 i_cmd,
    output tptq_pkg::t_status              o_status,
    input  tptq_pkg::t_func                i_func,
    input  logic [tptq_pkg::ID_W-1:0]      i_task_id,
    input  logic [tptq_pkg::PRI_IN_W-1:0]  i_task_priority,
    input  logic [tptq_pkg::TIME_IN_W-1:0] i_task_start,
    input  logic [tptq_pkg::TIME_IN_W-1:0] i_current_time,
    output logic                           o_valid,
    output logic [tptq_pkg::ID_W-1:0]      o_out_id,
    output logic                           o_dispatched,
    output logic                           o_cancel_found,
    output logic                           o_push_dropped,
    output logic                           o_queue_empty,
    output logic                           o_last
);
    import tptq_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(RESULT_LIMIT + 1);

    // Latched request
    t_func                   r_func;
    logic [ID_W-1:0]         r_id;
    logic [PRIORITY_WIDTH-1:0] r_pri;
    logic [TIME_WIDTH-1:0]   r_start;
    logic [TIME_WIDTH-1:0]   r_now;

    // Slot store
    logic [DEPTH-1:0]          r_valid;
    logic [DEPTH-1:0]          n_valid;
    logic [ID_W-1:0]           r_mem_id    [DEPTH];
    logic [PRIORITY_WIDTH-1:0] r_mem_pri   [DEPTH];
    logic [TIME_WIDTH-1:0]     r_mem_start [DEPTH];

    // Scan pipeline
    logic [IW-1:0]             r_scan;
    logic                      r_rd_live;
    logic [IW-1:0]             r_rd_idx;
    logic [ID_W-1:0]           r_rd_id;
    logic [PRIORITY_WIDTH-1:0] r_rd_pri;
    logic [TIME_WIDTH-1:0]     r_rd_start;

    // Best candidate of the current scan
    logic                      r_cand_hit;
    logic [IW-1:0]             r_cand_idx;
    logic [ID_W-1:0]           r_cand_id;
    logic [PRIORITY_WIDTH-1:0] r_cand_pri;
    logic [TIME_WIDTH-1:0]     r_cand_start;

    // Request bookkeeping
    logic                      r_found;
    logic [CW-1:0]             r_count;
    logic                      r_pend;
    logic [ID_W-1:0]           r_pend_id;

    // Result register
    logic                      r_o_valid;
    logic [ID_W-1:0]           r_o_id;
    logic                      r_o_disp;
    logic                      r_o_found;
    logic                      r_o_dropped;
    logic                      r_o_empty;
    logic                      r_o_last;
    logic                      n_o_valid;
    logic [ID_W-1:0]           n_o_id;
    logic                      n_o_disp;
    logic                      n_o_found;
    logic                      n_o_dropped;
    logic                      n_o_empty;
    logic                      n_o_last;

    logic [IW-1:0] free_idx;
    logic          has_free;
    logic          rd_vbit;
    logic          better;
    logic          cand_upd;
    logic          cancel_hit;
    logic          due;
    logic          take;

    // Lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IW'(i);
            end
        end
    end
    assign has_free = ~&r_valid;

    // Compare stage of the scan
    assign rd_vbit    = r_valid[r_rd_idx];
    assign better     = !r_cand_hit || (r_rd_pri > r_cand_pri) ||
                        ((r_rd_pri == r_cand_pri) && (r_rd_start < r_cand_start));
    assign cand_upd   = r_rd_live && rd_vbit && (r_func != F_CANCEL) && better;
    assign cancel_hit = r_rd_live && rd_vbit && (r_func == F_CANCEL) && (r_rd_id == r_id);

    // Dispatch decision on the finished scan; start equal to now is due
    assign due  = (r_func == F_DISP_ALL) || !(r_cand_start > r_now);
    assign take = r_cand_hit && due && (r_count < CW'(RESULT_LIMIT));

    assign o_status.scan_last = (r_scan == IW'(DEPTH - 1));
    assign o_status.take      = take;
    assign o_status.limit_hit = take && (r_count == CW'(RESULT_LIMIT - 1));

    // Valid bit updates
    always_comb begin
        n_valid = r_valid;
        if (i_cmd.push_do && has_free) begin
            n_valid[free_idx] = 1'b1;
        end
        if (cancel_hit) begin
            n_valid[r_rd_idx] = 1'b0;
        end
        if (i_cmd.decide && take) begin
            n_valid[r_cand_idx] = 1'b0;
        end
    end

    // Result selection; a dispatch is held one selection so that last is known
    always_comb begin
        n_o_valid   = 1'b0;
        n_o_id      = '0;
        n_o_disp    = 1'b0;
        n_o_found   = 1'b0;
        n_o_dropped = 1'b0;
        n_o_empty   = ~|r_valid;
        n_o_last    = 1'b1;
        if (i_cmd.push_do) begin
            n_o_valid   = 1'b1;
            n_o_dropped = ~has_free;
            n_o_empty   = 1'b0;   // pushed, or full
        end else if (i_cmd.cancel_emit) begin
            n_o_valid = 1'b1;
            n_o_found = r_found;
        end else if (i_cmd.decide) begin
            if (take) begin
                // next selection still valid, so the store is not empty
                n_o_valid = r_pend;
                n_o_id    = r_pend_id;
                n_o_disp  = 1'b1;
                n_o_empty = 1'b0;
                n_o_last  = 1'b0;
            end else begin
                n_o_valid = 1'b1;
                n_o_id    = r_pend ? r_pend_id : '0;
                n_o_disp  = r_pend;
            end
        end else if (i_cmd.flush) begin
            n_o_valid = 1'b1;
            n_o_id    = r_pend_id;
            n_o_disp  = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_scan     <= '0;
            r_rd_live  <= 1'b0;
            r_cand_hit <= 1'b0;
            r_found    <= 1'b0;
            r_count    <= '0;
            r_pend     <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_rd_live <= i_cmd.scan_issue;
            r_o_valid <= n_o_valid;
            if (i_cmd.load) begin
                r_scan <= '0;
            end else if (i_cmd.scan_issue) begin
                r_scan <= o_status.scan_last ? '0 : r_scan + 1'b1;
            end
            if (i_cmd.load || i_cmd.decide) begin
                r_cand_hit <= 1'b0;
            end else if (cand_upd) begin
                r_cand_hit <= 1'b1;
            end
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end else if (cancel_hit) begin
                r_found <= 1'b1;
            end
            if (i_cmd.load) begin
                r_count <= '0;
                r_pend  <= 1'b0;
            end else if (i_cmd.decide && take) begin
                r_count <= r_count + 1'b1;
                r_pend  <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_id    <= i_task_id;
            r_pri   <= PRIORITY_WIDTH'(i_task_priority);
            r_start <= TIME_WIDTH'(i_task_start);
            r_now   <= TIME_WIDTH'(i_current_time);
        end
        r_rd_idx <= r_scan;
        if (cand_upd) begin
            r_cand_idx   <= r_rd_idx;
            r_cand_id    <= r_rd_id;
            r_cand_pri   <= r_rd_pri;
            r_cand_start <= r_rd_start;
        end
        if (i_cmd.decide && take) begin
            r_pend_id <= r_cand_id;
        end
        r_o_id      <= n_o_id;
        r_o_disp    <= n_o_disp;
        r_o_found   <= n_o_found;
        r_o_dropped <= n_o_dropped;
        r_o_empty   <= n_o_empty;
        r_o_last    <= n_o_last;
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_do && has_free) begin
            r_mem_id[free_idx]    <= r_id;
            r_mem_pri[free_idx]   <= r_pri;
            r_mem_start[free_idx] <= r_start;
        end
        r_rd_id    <= r_mem_id[r_scan];
        r_rd_pri   <= r_mem_pri[r_scan];
        r_rd_start <= r_mem_start[r_scan];
    end

    assign o_valid        = r_o_valid;
    assign o_out_id       = r_o_id;
    assign o_dispatched   = r_o_disp;
    assign o_cancel_found = r_o_found;
    assign o_push_dropped = r_o_dropped;
    assign o_queue_empty  = r_o_empty;
    assign o_last         = r_o_last;

    // A dispatched candidate is a live slot
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.decide && take) |-> r_valid[r_cand_idx])
        else $error("dispatch of a slot that is not valid");

    // A successful push marks its slot valid
    a_push_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push_do && has_free) |=> r_valid[$past(free_idx)])
        else $error("pushed slot not marked valid");

    // Dispatch results carry no push or cancel flag
    a_disp_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_disp) |-> (!r_o_found && !r_o_dropped))
        else $error("dispatch result with foreign flag");

    // Never more dispatches than the result limit
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(RESULT_LIMIT))
        else $error("dispatch count over limit");

endmodule

/* hdl/timed_priority_task_queue_unit.sv */
// Push: result goes through the S_PUSH state and the result register. Cancel: a scan
// of every slot. Dispatch: each selection is a scan of the slot memory through its
// single read port, and one selection is made per dispatched task.
// One request at a time; busy is high from acceptance until the last result is set up.
// Synchronous active-low reset empties the store at once; the receiver cannot stall.
`timescale 1ns / 1ps

module timed_priority_task_queue_unit #(
    parameter int DEPTH          = tptq_pkg::DEPTH_DEF,
    parameter int PRIORITY_WIDTH = tptq_pkg::PRI_W_DEF,
    parameter int TIME_WIDTH     = tptq_pkg::TIME_W_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tptq_pkg::FUNC_W-1:0]    i_func,
    input  logic [tptq_pkg::ID_W-1:0]      i_task_id,
    input  logic [tptq_pkg::PRI_IN_W-1:0]  i_task_priority,
    input  logic [tptq_pkg::TIME_IN_W-1:0] i_task_start,
    input  logic [tptq_pkg::TIME_IN_W-1:0] i_current_time,
    output logic                           o_valid,
    output logic [tptq_pkg::ID_W-1:0]      o_out_id,
    output logic                           o_dispatched,
    output logic                           o_cancel_found,
    output logic                           o_push_dropped,
    output logic                           o_queue_empty,
    output logic                           o_last
);
    import tptq_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_func   func;

    assign func = t_func'(i_func);

    // Controller
    tptq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_func   (func),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // Datapath
    tptq_dp #(
        .DEPTH          (DEPTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH),
        .TIME_WIDTH     (TIME_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_func          (func),
        .i_task_id       (i_task_id),
        .i_task_priority (i_task_priority),
        .i_task_start    (i_task_start),
        .i_current_time  (i_current_time),
        .o_valid         (o_valid),
        .o_out_id        (o_out_id),
        .o_dispatched    (o_dispatched),
        .o_cancel_found  (o_cancel_found),
        .o_push_dropped  (o_push_dropped),
        .o_queue_empty   (o_queue_empty),
        .o_last          (o_last)
    );

endmodule

/* bench/testbench.sv */
// Self-checking bench for timed_priority_task_queue_unit: directed and random
// requests, results predicted by an in-bench model of the slot store.
// Depends on tptq_pkg and the unit under test.
`timescale 1ns / 1ps

module testbench;
    import tptq_pkg::*;

    localparam int SLOTS       = DEPTH_DEF;
    localparam int SETTLE      = 4 * (DEPTH_DEF + 3);
    localparam int CYCLE_LIMIT = 600000;
    localparam int RAND_ITEMS  = 100;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            dispatched;
        logic            cancel_found;
        logic            push_dropped;
        logic            queue_empty;
        logic            last;
    } t_outcome;

    // Predicts the outcomes of each accepted request and checks results in order
    class t_task_store_scoreboard;
        bit                 slot_valid [SLOTS];
        bit [ID_W-1:0]      slot_id    [SLOTS];
        bit [PRI_IN_W-1:0]  slot_pri   [SLOTS];
        bit [TIME_IN_W-1:0] slot_start [SLOTS];
        t_outcome           expected_q [$];
        int                 errors;

        function new();
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            errors = 0;
        endfunction

        function bit store_empty();
            foreach (slot_valid[i])
                if (slot_valid[i]) return 1'b0;
            return 1'b1;
        endfunction

        // Appends one predicted result at the tail of the queue
        function void add_expected(t_outcome r);
            expected_q.insert(expected_q.size(), r);
        endfunction

        // Highest priority, then earliest start, then lowest slot
        function int best_slot();
            int best;
            best = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!slot_valid[i]) continue;
                if (best < 0 || slot_pri[i] > slot_pri[best] ||
                    (slot_pri[i] == slot_pri[best] && slot_start[i] < slot_start[best]))
                    best = i;
            end
            return best;
        endfunction

        function void note_request(t_func op, bit [ID_W-1:0] id, bit [PRI_IN_W-1:0] pri,
                                   bit [TIME_IN_W-1:0] st, bit [TIME_IN_W-1:0] now);
            t_outcome o;
            t_outcome held;
            int       free_slot;
            int       b;
            int       n;
            bit       found;
            o = '0;
            case (op)
                F_PUSH: begin
                    free_slot = -1;
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!slot_valid[i]) free_slot = i;
                    if (free_slot >= 0) begin
                        slot_valid[free_slot] = 1'b1;
                        slot_id[free_slot]    = id;
                        slot_pri[free_slot]   = pri;
                        slot_start[free_slot] = st;
                    end
                    o.push_dropped = (free_slot < 0);
                    o.queue_empty  = store_empty();
                    o.last         = 1'b1;
                    add_expected(o);
                end
                F_CANCEL: begin
                    found = 1'b0;
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_valid[i] && slot_id[i] == id) begin
                            slot_valid[i] = 1'b0;
                            found = 1'b1;
                        end
                    o.cancel_found = found;
                    o.queue_empty  = store_empty();
                    o.last         = 1'b1;
                    add_expected(o);
                end
                default: begin
                    // Each dispatch is queued one step late so the final one gets last
                    n = 0;
                    held = '0;
                    while (n < RESULT_LIMIT) begin
                        b = best_slot();
                        if (b < 0) break;
                        if (op == F_DISP_READY && slot_start[b] > now) break;
                        slot_valid[b] = 1'b0;
                        if (n > 0) add_expected(held);
                        held = '0;
                        held.id          = slot_id[b];
                        held.dispatched  = 1'b1;
                        held.queue_empty = store_empty();
                        n++;
                    end
                    if (n == 0) begin
                        o.queue_empty = store_empty();
                        o.last        = 1'b1;
                        add_expected(o);
                    end else begin
                        held.last = 1'b1;
                        add_expected(held);
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
            if (exp !== act) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(t_outcome got);
            t_outcome exp;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual out_id %0h",
                         $time, got.id);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            compare_field("out_id",       32'(exp.id),           32'(got.id));
            compare_field("dispatched",   32'(exp.dispatched),   32'(got.dispatched));
            compare_field("cancel_found", 32'(exp.cancel_found), 32'(got.cancel_found));
            compare_field("push_dropped", 32'(exp.push_dropped), 32'(got.push_dropped));
            compare_field("queue_empty",  32'(exp.queue_empty),  32'(got.queue_empty));
            compare_field("last",         32'(exp.last),         32'(got.last));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [FUNC_W-1:0]    i_func;
    logic [ID_W-1:0]      i_task_id;
    logic [PRI_IN_W-1:0]  i_task_priority;
    logic [TIME_IN_W-1:0] i_task_start;
    logic [TIME_IN_W-1:0] i_current_time;
    logic                 o_valid;
    logic [ID_W-1:0]      o_out_id;
    logic                 o_dispatched;
    logic                 o_cancel_found;
    logic                 o_push_dropped;
    logic                 o_queue_empty;
    logic                 o_last;

    t_task_store_scoreboard sb = new();
    int                     cycle_count = 0;
    int                     sender_idle_pct = 0;
    logic [TIME_IN_W-1:0]   tick_base = '0;

    timed_priority_task_queue_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_task_id       (i_task_id),
        .i_task_priority (i_task_priority),
        .i_task_start    (i_task_start),
        .i_current_time  (i_current_time),
        .o_valid         (o_valid),
        .o_out_id        (o_out_id),
        .o_dispatched    (o_dispatched),
        .o_cancel_found  (o_cancel_found),
        .o_push_dropped  (o_push_dropped),
        .o_queue_empty   (o_queue_empty),
        .o_last          (o_last)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Results are checked before the request taken at the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1)
                sb.check_result({o_out_id, o_dispatched, o_cancel_found,
                                 o_push_dropped, o_queue_empty, o_last});
            if (start === 1'b1 && busy === 1'b0)
                sb.note_request(t_func'(i_func), i_task_id, i_task_priority,
                                i_task_start, i_current_time);
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Drives one request and returns at the edge that accepts it; start stays high
    task send_request(input t_func op, input logic [ID_W-1:0] id,
                      input logic [PRI_IN_W-1:0] pri, input logic [TIME_IN_W-1:0] st,
                      input logic [TIME_IN_W-1:0] now);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct && gap < 20) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_func          <= op;
        i_task_id       <= id;
        i_task_priority <= pri;
        i_task_start    <= st;
        i_current_time  <= now;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Sender holds off until every outstanding result has come, then lets the unit settle;
    // the first wait makes sure the request accepted at the previous edge is already noted
    task wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Mostly a small id pool and times near a moving time base, often low priorities; some full-range values
    task random_request();
        int                   pick;
        t_func                op;
        logic [ID_W-1:0]      id;
        logic [PRI_IN_W-1:0]  pri;
        logic [TIME_IN_W-1:0] st;
        logic [TIME_IN_W-1:0] now;
        pick = $urandom_range(0, 99);
        if (pick < 50)      op = F_PUSH;
        else if (pick < 65) op = F_CANCEL;
        else if (pick < 90) op = F_DISP_READY;
        else                op = F_DISP_ALL;
        tick_base = tick_base + $urandom_range(0, 40);
        id  = ($urandom_range(0, 9) < 7) ? ID_W'(16'hA5A0 + $urandom_range(0, 7))
                                         : ID_W'($urandom);
        pri = ($urandom_range(0, 1) != 0) ? PRI_IN_W'($urandom_range(0, 3))
                                          : PRI_IN_W'($urandom);
        st  = ($urandom_range(0, 9) < 8) ? tick_base + $urandom_range(0, 200) : $urandom;
        now = ($urandom_range(0, 9) < 8) ? tick_base + $urandom_range(0, 200) : $urandom;
        send_request(op, id, pri, st, now);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_func          <= F_PUSH;
        i_task_id       <= '0;
        i_task_priority <= '0;
        i_task_start    <= '0;
        i_current_time  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty store, field extremes, tie breaks, due boundary
        sender_idle_pct = 34;
        send_request(F_DISP_ALL,   16'h0000,  8'd0,   32'h0000_0000, 32'h0000_0000);
        send_request(F_PUSH,       16'hFFFF,  8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(F_PUSH,       16'h0000,  8'd0,   32'h0000_0000, 32'h0000_0000);
        send_request(F_PUSH,       16'h1234,  8'd255, 32'h0000_0000, 32'h0000_0000);
        send_request(F_PUSH,       16'h0007,  8'd0,   32'h0000_0000, 32'hFFFF_FFFF);
        // Best entry not yet due blocks lower entries that are due
        send_request(F_DISP_READY, 16'h0000,  8'd0,   32'h0000_0000, 32'h0000_0000);
        send_request(F_DISP_READY, 16'hFFFF,  8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        // Start equal to current time counts as due
        send_request(F_DISP_READY, 16'h0000,  8'd0,   32'h0000_0000, 32'hFFFF_FFFF);

        // Fill the store with repeated ids, then overflow, cancel and drain
        for (int k = 0; k < SLOTS; k++)
            send_request(F_PUSH, ID_W'((k % 3 == 0) ? 16'hAAAA : 16'h5500 + k),
                         8'(k * 16), 32'(k * 1000), 32'h0);
        send_request(F_PUSH,       16'h0F0F,  8'd200, 32'd5,         32'h0);
        send_request(F_CANCEL,     16'hAAAA,  8'd0,   32'h0,         32'h0);
        send_request(F_CANCEL,     16'hAAAA,  8'd0,   32'h0,         32'h0);
        send_request(F_DISP_READY, 16'h0000,  8'd0,   32'h0,         32'd7000);
        send_request(F_DISP_ALL,   16'h0000,  8'd0,   32'h0,         32'h0);

        for (int n = 0; n < RAND_ITEMS; n++) random_request();
        wait_for_results();

        sender_idle_pct = 61;
        for (int n = 0; n < RAND_ITEMS; n++) random_request();
        wait_for_results();

        sender_idle_pct = 0;
        for (int n = 0; n < RAND_ITEMS; n++) random_request();
        wait_for_results();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
